// ===== hdl/add_hours_to_civil_datetime_assert.svh =====
// Assertion macros for the civil date-time hour adder.
// Standalone header; included by the top level only.
`ifndef ADD_HOURS_TO_CIVIL_DATETIME_ASSERT_SVH
`define ADD_HOURS_TO_CIVIL_DATETIME_ASSERT_SVH

`ifndef SYNTHESIS
`define AHCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AHCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AHCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AHCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/ahcd_pkg.sv =====
// Constants, types and calendar tables for the civil date-time hour adder.
// No dependencies.
package ahcd_pkg;

	localparam int unsigned NSTG = 11;

	localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [5:0]  MAX_ERA       = 6'd42;

	// offset bias: multiple of 24 that makes any 21-bit offset nonnegative
	localparam logic [21:0] OFF_BIAS     = 22'd1048584;
	localparam logic [16:0] OFF_DAY_BIAS = 17'd43691;

	// reciprocal multipliers, exact over the operand ranges used here
	localparam logic [17:0] DIV3_RECIP   = 18'd174763; // >> 19, n < 2^19
	localparam logic [12:0] DIV100_RECIP = 13'd5243;   // >> 19, n < 43699
	localparam logic [15:0] DIV365_RECIP = 16'd45965;  // >> 24, n < 1.8M
	localparam logic [22:0] ERA_RECIP    = 23'd7525902; // >> 40, n < 2^23

	// shifted year limits: output year 1..9999 plus the 400-year bias
	localparam logic [14:0] YEAR_LO = 15'd401;
	localparam logic [14:0] YEAR_HI = 15'd10399;
	localparam logic [14:0] YEAR_BIAS = 15'd400;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// first day of each month in a March-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// year bias for a raw month: folds month 0 and 13..15 and the
	// Jan/Feb borrow into the March-based year, plus 400 years
	function automatic logic [8:0] year_bias(input logic [3:0] mo);
		logic [8:0] r;
		unique case (mo)
			4'd0, 4'd1, 4'd2: r = 9'd399;
			4'd15:            r = 9'd401;
			default:          r = 9'd400;
		endcase
		return r;
	endfunction

	// raw month to March-based month index 0..11
	function automatic logic [3:0] march_month(input logic [3:0] mo);
		logic [3:0] r;
		if (mo <= 4'd2) begin
			r = mo + 4'd9;
		end else if (mo == 4'd15) begin
			r = 4'd0;
		end else begin
			r = mo - 4'd3;
		end
		return r;
	endfunction

endpackage

// ===== hdl/add_hours_to_civil_datetime.sv =====
// Civil date-time hour adder, top level; uses ahcd_pkg and the assert macros.
//
// Usage: one input transaction carries a Gregorian UTC date and time and a
// signed hour offset; one output transaction returns the shifted date and
// time, or all zero fields with range_error set when the year leaves 1..9999.
// Both channels use valid/stall: a transaction moves on a rising edge with
// valid high and stall low. The block drives in_stall and watches out_stall.
// An accepted transaction passes through every stage register in order.
// Throughput, while out_stall is low, is one transaction per cycle, set by
// the 11-stage pipeline of constant multiplies and short add chains.
// When out_stall is held, the pipeline keeps filling bubbles and then
// raises in_stall once every stage holds a transaction; none are lost or
// repeated. arst_n clears all stage valid bits; payload is not reset.
// Internally the date becomes a day count (days-from-civil, biased by 400
// years so it stays positive), the offset is split into days and hours by
// a reciprocal divide by 24, and the sum is converted back by era, year of
// era and day of year.
`include "add_hours_to_civil_datetime_assert.svh"

module add_hours_to_civil_datetime
	import ahcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [13:0]        in_year,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [4:0]         in_hour,
	input  logic [5:0]         in_minute,
	input  logic [5:0]         in_second,
	input  logic signed [20:0] hour_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [13:0]        out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic [4:0]         out_hour,
	output logic [5:0]         out_minute,
	output logic [5:0]         out_second,
	output logic               range_error
);

	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	// stage k loads when empty or when stage k+1 loads
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// ---------------- stage 1: fold month, wrap seconds/minutes, bias offset
	logic        s_wrap, m_wrap;
	logic [5:0]  sec_n, min_n;
	logic [6:0]  min_t;
	logic [14:0] yr_n;
	logic [21:0] u_n;

	assign s_wrap = in_second >= 6'd60;
	assign sec_n  = s_wrap ? in_second - 6'd60 : in_second;
	assign min_t  = {1'b0, in_minute} + {6'b0, s_wrap};
	assign m_wrap = min_t >= 7'd60;
	assign min_n  = m_wrap ? 6'(min_t - 7'd60) : min_t[5:0];
	assign yr_n   = {1'b0, in_year} + {6'b0, year_bias(in_month)};
	assign u_n    = {hour_offset[20], hour_offset} + OFF_BIAS;

	logic [14:0] yr_s1;
	logic [3:0]  mp_s1;
	logic [4:0]  day_s1;
	logic        cmin_s1;
	hms_t        hms_s1;
	logic [21:0] u_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			yr_s1   <= yr_n;
			mp_s1   <= march_month(in_month);
			day_s1  <= in_day;
			cmin_s1 <= m_wrap;
			hms_s1  <= '{hour: in_hour, minute: min_n, second: sec_n};
			u_s1    <= u_n;
		end
	end

	// ---------------- stage 2: constant multiplies
	logic [36:0] q_prod;
	logic [27:0] hund_prod;
	logic [25:0] c400_prod;
	logic [23:0] y365_full;

	assign q_prod    = 37'(u_s1[21:3]) * 37'(DIV3_RECIP);
	assign hund_prod = 28'(yr_s1) * 28'(DIV100_RECIP);
	assign c400_prod = 26'(yr_s1[14:2]) * 26'(DIV100_RECIP);
	assign y365_full = 24'(yr_s1) * 24'(DAYS_PER_YEAR);

	logic [16:0] q_s2;
	logic [7:0]  hund_s2;
	logic [5:0]  c400_s2;
	logic [22:0] y365_s2;
	logic [12:0] yq_s2;
	logic [3:0]  mp_s2;
	logic [4:0]  day_s2;
	logic        cmin_s2;
	hms_t        hms_s2;
	logic [4:0]  ulo_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			q_s2    <= q_prod[35:19];
			hund_s2 <= hund_prod[26:19];
			c400_s2 <= c400_prod[24:19];
			y365_s2 <= y365_full[22:0];
			yq_s2   <= yr_s1[14:2];
			mp_s2   <= mp_s1;
			day_s2  <= day_s1;
			cmin_s2 <= cmin_s1;
			hms_s2  <= hms_s1;
			ulo_s2  <= u_s1[4:0];
		end
	end

	// ---------------- stage 3: offset hours mod 24, day count of the date
	logic [4:0]  q24_lo, rem;
	logic [5:0]  hsum;
	logic [23:0] d0_full;

	// true remainder is below 24, so five low bits are exact
	assign q24_lo  = {q_s2[0], 4'b0000} + {q_s2[1:0], 3'b000};
	assign rem     = ulo_s2 - q24_lo;
	assign hsum    = {1'b0, hms_s2.hour} + {5'b0, cmin_s2} + {1'b0, rem};
	assign d0_full = {1'b0, y365_s2} + 24'(yq_s2) - 24'(hund_s2) + 24'(c400_s2)
		+ 24'(month_start(mp_s2)) + 24'(day_s2) - 24'd1;

	logic [5:0]  hsum_s3;
	logic [22:0] d0_s3;
	logic [16:0] q_s3;
	hms_t        hms_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			hsum_s3 <= hsum;
			d0_s3   <= d0_full[22:0];
			q_s3    <= q_s2;
			hms_s3  <= hms_s2;
		end
	end

	// ---------------- stage 4: hour carry, total day count
	logic [1:0]  dc;
	logic [5:0]  hr_n;
	logic [23:0] z_full;

	always_comb begin
		priority if (hsum_s3 >= 6'd48) begin
			dc   = 2'd2;
			hr_n = hsum_s3 - 6'd48;
		end else if (hsum_s3 >= 6'd24) begin
			dc   = 2'd1;
			hr_n = hsum_s3 - 6'd24;
		end else begin
			dc   = 2'd0;
			hr_n = hsum_s3;
		end
	end

	assign z_full = {1'b0, d0_s3} + 24'(q_s3) + 24'(dc) - 24'(OFF_DAY_BIAS);

	logic [22:0] z_s4;
	hms_t        hms_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			z_s4   <= z_full[22:0];
			hms_s4 <= '{hour: hr_n[4:0], minute: hms_s3.minute, second: hms_s3.second};
		end
	end

	// ---------------- stage 5: era = days / 146097
	logic [45:0] era_prod;

	assign era_prod = 46'(z_s4) * 46'(ERA_RECIP);

	logic [5:0]  era_s5;
	logic [22:0] z_s5;
	hms_t        hms_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			era_s5 <= era_prod[45:40];
			z_s5   <= z_s4;
			hms_s5 <= hms_s4;
		end
	end

	// ---------------- stage 6: day of era
	logic [22:0] era_days, doe_full;

	assign era_days = 23'(era_s5) * 23'(DAYS_PER_ERA);
	assign doe_full = z_s5 - era_days;

	logic [17:0] doe_s6;
	logic [5:0]  era_s6;
	hms_t        hms_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			doe_s6 <= doe_full[17:0];
			era_s6 <= era_s5;
			hms_s6 <= hms_s5;
		end
	end

	// ---------------- stage 7: leap corrections of the day of era
	logic [31:0] a_prod;
	logic [2:0]  cent;

	assign a_prod = 32'(doe_s6[17:2]) * 32'(DIV365_RECIP);
	assign cent   = {2'b0, doe_s6 >= 18'd36524} + {2'b0, doe_s6 >= 18'd73048}
		+ {2'b0, doe_s6 >= 18'd109572} + {2'b0, doe_s6 >= 18'd146096};

	logic [6:0]  a_s7;
	logic [2:0]  b_s7;
	logic        c_s7;
	logic [17:0] doe_s7;
	logic [5:0]  era_s7;
	hms_t        hms_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			a_s7   <= a_prod[30:24];
			b_s7   <= cent;
			c_s7   <= doe_s6 == 18'd146096;
			doe_s7 <= doe_s6;
			era_s7 <= era_s6;
			hms_s7 <= hms_s6;
		end
	end

	// ---------------- stage 8: corrected day of era
	logic [17:0] t_s8, doe_s8;
	logic [5:0]  era_s8;
	hms_t        hms_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			t_s8   <= doe_s7 - 18'(a_s7) + 18'(b_s7) - 18'(c_s7);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
			hms_s8 <= hms_s7;
		end
	end

	// ---------------- stage 9: year of era
	logic [33:0] yoe_prod;

	assign yoe_prod = 34'(t_s8) * 34'(DIV365_RECIP);

	logic [8:0]  yoe_s9;
	logic [17:0] doe_s9;
	logic [5:0]  era_s9;
	hms_t        hms_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			yoe_s9 <= yoe_prod[32:24];
			doe_s9 <= doe_s8;
			era_s9 <= era_s8;
			hms_s9 <= hms_s8;
		end
	end

	// ---------------- stage 10: day of year, biased March-based year
	logic [1:0]  yh;
	logic [17:0] ydays, doy_full;

	assign yh = {1'b0, yoe_s9 >= 9'd100} + {1'b0, yoe_s9 >= 9'd200}
		+ {1'b0, yoe_s9 >= 9'd300};
	assign ydays    = 18'(yoe_s9) * 18'(DAYS_PER_YEAR) + 18'(yoe_s9[8:2]) - 18'(yh);
	assign doy_full = doe_s9 - ydays;

	logic [8:0]  doy_s10;
	logic [14:0] ybase_s10;
	hms_t        hms_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			doy_s10   <= doy_full[8:0];
			ybase_s10 <= 15'(era_s9) * YEAR_BIAS + 15'(yoe_s9);
			hms_s10   <= hms_s9;
		end
	end

	// ---------------- stage 11: month, day, year, range check
	logic [3:0]  mp_n, mon_n;
	logic [8:0]  day_full;
	logic [14:0] yfull;
	logic        jf, err_n;

	always_comb begin
		mp_n = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s10 >= month_start(4'(i))) begin
				mp_n = 4'(i);
			end
		end
	end

	// January and February belong to the next civil year
	assign jf       = mp_n >= 4'd10;
	assign mon_n    = jf ? mp_n - 4'd9 : mp_n + 4'd3;
	assign day_full = doy_s10 - month_start(mp_n) + 9'd1;
	assign yfull    = ybase_s10 + {14'b0, jf};
	assign err_n    = (yfull < YEAR_LO) || (yfull > YEAR_HI);

	logic [13:0] year_s11;
	logic [3:0]  month_s11;
	logic [4:0]  day_s11;
	hms_t        hms_s11;
	logic        err_s11;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			err_s11 <= err_n;
			if (err_n) begin
				year_s11  <= '0;
				month_s11 <= '0;
				day_s11   <= '0;
				hms_s11   <= '0;
			end else begin
				year_s11  <= 14'(yfull - YEAR_BIAS);
				month_s11 <= mon_n;
				day_s11   <= day_full[4:0];
				hms_s11   <= hms_s10;
			end
		end
	end

	assign out_year    = year_s11;
	assign out_month   = month_s11;
	assign out_day     = day_s11;
	assign out_hour    = hms_s11.hour;
	assign out_minute  = hms_s11.minute;
	assign out_second  = hms_s11.second;
	assign range_error = err_s11;

	// ---------------- checks
	`AHCD_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, out_valid && out_stall,
		"in_stall raised while the pipeline can still move")
	`AHCD_ASSERT_NXT(a_hold_tail, clk, arst_n,
		out_valid && out_stall && vld_q[NSTG-1], out_valid && vld_q[NSTG-1],
		"stalled pipeline dropped a transaction")
	`AHCD_ASSERT_IMP(a_era_bound, clk, arst_n, vld_q[5], era_s5 <= MAX_ERA,
		"era out of range")
	`AHCD_ASSERT_IMP(a_doe_bound, clk, arst_n, vld_q[6], doe_s6 < DAYS_PER_ERA,
		"day of era out of range")
	`AHCD_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && range_error,
		out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0
		&& out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0,
		"range error with nonzero fields")
	`AHCD_ASSERT_IMP(a_fields_ok, clk, arst_n, out_valid && !range_error,
		out_month >= 4'd1 && out_month <= 4'd12 && out_day != 5'd0
		&& out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60
		&& out_year != 14'd0 && out_year <= 14'd9999,
		"result fields out of range")

endmodule
